[rtl/gdad_pkg.sv]
package gdad_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int ADD_W    = 15;
   // walk year can run past the 14-bit field before it wraps on output
   localparam int WYEAR_W  = YEAR_W + 1;
   // day-of-year remainder: start day + days to add + one year of months
   localparam int REM_W    = 16;
   localparam int MLEN_W   = 5;
   localparam int YLEN_W   = 9;
   localparam int YMOD_W   = 9;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [YMOD_W-1:0] CYCLE_YEARS   = 9'd400;
   localparam logic [YMOD_W-1:0] CENTURY_YEARS = 9'd100;
   localparam logic [YMOD_W-1:0] CYCLE_LAST    = 9'd399;

   // year mod 400 by restoring compare-subtract of 400 shifted left
   localparam int RED_STEPS = 6;
   localparam int RED_IDX_W = 3;
   localparam logic [RED_IDX_W-1:0] RED_LAST = 3'(RED_STEPS - 1);

   localparam logic [YLEN_W-1:0] YEAR_LEN_COMMON = 9'd365;
   localparam logic [YLEN_W-1:0] YEAR_LEN_LEAP   = 9'd366;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_PRE,
      OP_YEAR,
      OP_MONTH,
      OP_CAPTURE
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [RED_IDX_W-1:0]   red_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic pre_more;
      logic year_more;
      logic month_more;
   } dp_stat_type;

   // leap from low two year bits and year mod 400
   function automatic logic is_leap(input logic [1:0] y_lo, input logic [YMOD_W-1:0] ymod);
      logic century;
      century = (ymod == CENTURY_YEARS) || (ymod == 9'(2 * CENTURY_YEARS))
             || (ymod == 9'(3 * CENTURY_YEARS));
      return (ymod == '0) || ((y_lo == 2'd0) && !century);
   endfunction

   function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [MLEN_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

[rtl/gdad_ctrl.sv]
module gdad_ctrl
   import gdad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_PRE,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [RED_IDX_W-1:0]    red_idx_ff, red_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      red_idx_in   = red_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.red_idx  = red_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op     = OP_LOAD;
               red_idx_in = '0;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.op = OP_REDUCE;
            if (red_idx_ff == RED_LAST) begin
               state_in = ST_PRE;
            end else begin
               red_idx_in = red_idx_ff + 3'd1;
            end
         end
         ST_PRE: begin
            cmd.op = OP_PRE;
            if (!stat.pre_more) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            cmd.op = OP_YEAR;
            if (!stat.year_more) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.op = OP_MONTH;
            if (!stat.month_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op       = OP_CAPTURE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         red_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_idx_ff   <= red_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/gdad_dpath.sv]
module gdad_dpath
   import gdad_pkg::*;
(
   input  logic                clock,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [DAY_W-1:0]    req_start_day,
   input  logic [MONTH_W-1:0]  req_start_month,
   input  logic [YEAR_W-1:0]   req_start_year,
   input  logic [ADD_W-1:0]    req_days_to_add,
   output logic [DAY_W-1:0]    rsp_result_day,
   output logic [MONTH_W-1:0]  rsp_result_month,
   output logic [YEAR_W-1:0]   rsp_result_year
);

   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [WYEAR_W-1:0]  year_ff, year_in;
   logic [YEAR_W-1:0]   ymod_ff, ymod_in;
   logic [MONTH_W-1:0]  mcnt_ff, mcnt_in;
   logic [MONTH_W-1:0]  smonth_ff, smonth_in;
   logic [DAY_W-1:0]    rday_ff, rday_in;
   logic [MONTH_W-1:0]  rmonth_ff, rmonth_in;
   logic [YEAR_W-1:0]   ryear_ff, ryear_in;

   logic                leap;
   logic [MLEN_W-1:0]   mlen;
   logic [YLEN_W-1:0]   ylen;
   logic [YEAR_W-1:0]   sub_val;
   logic [YEAR_W-1:0]   ymod_next;

   assign leap      = is_leap(year_ff[1:0], ymod_ff[YMOD_W-1:0]);
   assign mlen      = month_len(mcnt_ff, leap);
   assign ylen      = leap ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;
   assign sub_val   = YEAR_W'(CYCLE_YEARS) << (RED_LAST - cmd.red_idx);
   assign ymod_next = (ymod_ff[YMOD_W-1:0] == CYCLE_LAST) ? '0 : ymod_ff + 14'd1;

   assign stat.pre_more   = (mcnt_ff < smonth_ff) && (mcnt_ff <= MONTH_DEC);
   assign stat.year_more  = rem_ff > REM_W'(ylen);
   assign stat.month_more = rem_ff > REM_W'(mlen);

   always_comb begin
      rem_in    = rem_ff;
      year_in   = year_ff;
      ymod_in   = ymod_ff;
      mcnt_in   = mcnt_ff;
      smonth_in = smonth_ff;
      rday_in   = rday_ff;
      rmonth_in = rmonth_ff;
      ryear_in  = ryear_ff;
      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            rem_in    = REM_W'(req_start_day) + REM_W'(req_days_to_add);
            year_in   = WYEAR_W'(req_start_year);
            ymod_in   = req_start_year;
            mcnt_in   = MONTH_JAN;
            smonth_in = req_start_month;
         end
         OP_REDUCE: begin
            if (ymod_ff >= sub_val) begin
               ymod_in = ymod_ff - sub_val;
            end
         end
         OP_PRE: begin
            if (stat.pre_more) begin
               rem_in  = rem_ff + REM_W'(mlen);
               mcnt_in = mcnt_ff + 4'd1;
            end
         end
         OP_YEAR: begin
            if (stat.year_more) begin
               rem_in  = rem_ff - REM_W'(ylen);
               year_in = year_ff + 15'd1;
               ymod_in = ymod_next;
            end else begin
               mcnt_in = MONTH_JAN;
            end
         end
         OP_MONTH: begin
            if (stat.month_more) begin
               rem_in = rem_ff - REM_W'(mlen);
               if (mcnt_ff == MONTH_DEC) begin
                  mcnt_in = MONTH_JAN;
                  year_in = year_ff + 15'd1;
                  ymod_in = ymod_next;
               end else begin
                  mcnt_in = mcnt_ff + 4'd1;
               end
            end
         end
         OP_CAPTURE: begin
            rday_in   = rem_ff[DAY_W-1:0];
            rmonth_in = mcnt_ff;
            ryear_in  = year_ff[YEAR_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      year_ff   <= year_in;
      ymod_ff   <= ymod_in;
      mcnt_ff   <= mcnt_in;
      smonth_ff <= smonth_in;
      rday_ff   <= rday_in;
      rmonth_ff <= rmonth_in;
      ryear_ff  <= ryear_in;
   end

   assign rsp_result_day   = rday_ff;
   assign rsp_result_month = rmonth_ff;
   assign rsp_result_year  = ryear_ff;

endmodule

[rtl/gregorian_date_add_days.sv]
// gregorian date plus a day count, one transaction at a time
// steps: load, year mod 400, months before start, year skip, month walk, capture;
//   the year-skip loop removes one year per cycle
// the next request is taken once the result sits in the output register
// reset: synchronous active high, clears the controller and rsp_valid
module gregorian_date_add_days
   import gdad_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DAY_W-1:0]    req_start_day,
   input  logic [MONTH_W-1:0]  req_start_month,
   input  logic [YEAR_W-1:0]   req_start_year,
   input  logic [ADD_W-1:0]    req_days_to_add,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DAY_W-1:0]    rsp_result_day,
   output logic [MONTH_W-1:0]  rsp_result_month,
   output logic [YEAR_W-1:0]   rsp_result_year
);

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: load, year mod 400, months before start, year skip, month walk, capture
   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // remainder, walk year, year mod 400, month counter and result register
   gdad_dpath u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .stat             (stat),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_days_to_add  (req_days_to_add),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year)
   );

endmodule
